// ===== hw/rtl/dsrts_pkg.sv =====
// shared types and constants for the dual servo turnout driver
package dsrts_pkg;

   localparam int WidthBits = 8;

   typedef enum logic [1:0] {
      CODE_UNKNOWN = 2'd0,
      CODE_LEFT    = 2'd1,
      CODE_RIGHT   = 2'd2,
      CODE_CENTER  = 2'd3
   } code_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_INIT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      REG_UPPER_LIMIT = 2'd0,
      REG_LOWER_LIMIT = 2'd1,
      REG_RAMP_RATE   = 2'd2,
      REG_STALL_TICKS = 2'd3
   } reg_index_type;

   localparam logic [WidthBits-1:0] UpperLimitReset = 8'd170;
   localparam logic [WidthBits-1:0] LowerLimitReset = 8'd80;
   localparam logic [WidthBits-1:0] RampRateReset   = 8'd2;
   localparam logic [WidthBits-1:0] StallTicksReset = 8'd50;
   localparam logic [WidthBits-1:0] WidthReset      = 8'd125;
   localparam logic [WidthBits-1:0] StallCountReset = 8'd50;

   localparam logic [7:0] MainLampsAllRed = 8'hAA;
   localparam logic [1:0] LowerLampGreen  = 2'd1;
   localparam logic [1:0] LowerLampRed    = 2'd2;
   localparam logic [1:0] LowerLampYellow = 2'd3;

   typedef struct packed {
      logic [WidthBits-1:0] upper_limit;
      logic [WidthBits-1:0] lower_limit;
      logic [WidthBits-1:0] ramp_rate;
      logic [WidthBits-1:0] stall_ticks;
   } cfg_type;

   typedef struct packed {
      logic [WidthBits-1:0] width_one;
      logic [WidthBits-1:0] width_two;
      logic [WidthBits-1:0] stall_count;
   } state_type;

   typedef struct packed {
      logic [WidthBits-1:0] servo_one_width;
      logic [WidthBits-1:0] servo_two_width;
      logic                 pulse_active;
      logic [7:0]           main_lamps;
      logic [1:0]           lower_lamps;
   } result_type;

endpackage

// ===== hw/rtl/dsrts_core.sv =====
// servo init and ramp, stall countdown and lamp decode for one word
module dsrts_core import dsrts_pkg::*; (
   input  kind_type  kind,
   input  code_type  code,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output result_type result
);

   function automatic logic [WidthBits-1:0] ramp_down(input logic [WidthBits-1:0] w,
                                                      input cfg_type c);
      logic [WidthBits:0] floor_sum;
      begin
         floor_sum = {1'b0, c.lower_limit} + {1'b0, c.ramp_rate};
         if ({1'b0, w} >= floor_sum) begin
            ramp_down = w - c.ramp_rate;
         end else begin
            ramp_down = c.lower_limit;
         end
      end
   endfunction

   function automatic logic [WidthBits-1:0] ramp_up(input logic [WidthBits-1:0] w,
                                                    input cfg_type c);
      logic [WidthBits:0] sum;
      begin
         sum = {1'b0, w} + {1'b0, c.ramp_rate};
         if (sum <= {1'b0, c.upper_limit}) begin
            ramp_up = sum[WidthBits-1:0];
         end else begin
            ramp_up = c.upper_limit;
         end
      end
   endfunction

   logic [WidthBits-1:0] w1;
   logic [WidthBits-1:0] w2;
   logic [WidthBits-1:0] count_loaded;
   logic [WidthBits:0]   mid_sum;
   logic                 between_any;
   logic                 pulse;
   logic                 one_up, one_lo, two_up, two_lo;
   logic                 left_g, center_g, right_g;

   assign mid_sum = {1'b0, cfg.upper_limit} + {1'b0, cfg.lower_limit};

   always_comb begin
      w1 = state.width_one;
      w2 = state.width_two;
      if (kind == KIND_INIT) begin
         case (code)
            CODE_LEFT: begin
               w1 = cfg.upper_limit;
               w2 = cfg.upper_limit;
            end
            CODE_CENTER: begin
               w1 = cfg.lower_limit;
               w2 = cfg.upper_limit;
            end
            CODE_RIGHT: begin
               w1 = cfg.lower_limit;
               w2 = cfg.lower_limit;
            end
            default: begin
               w1 = mid_sum[WidthBits:1];
               w2 = mid_sum[WidthBits:1];
            end
         endcase
      end else begin
         case (code)
            CODE_LEFT: begin
               w1 = ramp_down(state.width_one, cfg);
               w2 = ramp_up(state.width_two, cfg);
            end
            CODE_CENTER: begin
               w1 = ramp_down(state.width_one, cfg);
               w2 = ramp_down(state.width_two, cfg);
            end
            CODE_RIGHT: begin
               w1 = ramp_up(state.width_one, cfg);
               w2 = ramp_down(state.width_two, cfg);
            end
            default: begin
               w1 = state.width_one;
               w2 = state.width_two;
            end
         endcase
      end
   end

   assign between_any = (w1 < cfg.upper_limit && w1 > cfg.lower_limit) ||
                        (w2 < cfg.upper_limit && w2 > cfg.lower_limit);

   assign count_loaded = (code != CODE_UNKNOWN && between_any) ? cfg.stall_ticks
                                                                : state.stall_count;
   assign pulse = (count_loaded != '0);

   // equal limits count as upper
   assign one_up = (w1 == cfg.upper_limit);
   assign one_lo = !one_up && (w1 == cfg.lower_limit);
   assign two_up = (w2 == cfg.upper_limit);
   assign two_lo = !two_up && (w2 == cfg.lower_limit);

   assign left_g   = one_lo && two_up && (code == CODE_LEFT);
   assign center_g = one_lo && two_lo && (code == CODE_CENTER);
   assign right_g  = one_up && two_lo && (code == CODE_RIGHT);

   always_comb begin
      state_next.width_one = w1;
      state_next.width_two = w2;
      result.servo_one_width = w1;
      result.servo_two_width = w2;
      if (kind == KIND_INIT) begin
         state_next.stall_count = cfg.stall_ticks;
         result.pulse_active    = 1'b0;
         result.main_lamps      = MainLampsAllRed;
         result.lower_lamps     = LowerLampRed;
      end else begin
         state_next.stall_count = pulse ? count_loaded - 1'b1 : count_loaded;
         result.pulse_active    = pulse;
         result.main_lamps      = {!center_g, center_g, !left_g, left_g,
                                   !center_g, center_g, !right_g, right_g};
         if (left_g) begin
            result.lower_lamps = LowerLampGreen;
         end else if (right_g) begin
            result.lower_lamps = LowerLampYellow;
         end else begin
            result.lower_lamps = LowerLampRed;
         end
      end
   end

endmodule

// ===== hw/rtl/dual_servo_ramp_turnout_signal.sv =====
// top level of the dual servo turnout driver with signal lamps
// a request word goes to the input register, its response word to the output register
// throughput: one word per cycle; the servo state updates as a word leaves the input register
// a stalled response holds the input register, which then stalls the request side
// reset: synchronous, active high; restores register defaults, widths 125, countdown 50
module dual_servo_ramp_turnout_signal import dsrts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [1:0]           req_switch_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WidthBits-1:0] rsp_servo_one_width,
   output logic [WidthBits-1:0] rsp_servo_two_width,
   output logic                 rsp_pulse_active,
   output logic [7:0]           rsp_main_lamps,
   output logic [1:0]           rsp_lower_lamps,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [WidthBits-1:0] csr_data
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       in_valid_ff;
   kind_type   kind_ff;
   code_type   code_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       take_req;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   dsrts_core u_core (
      .kind       (kind_ff),
      .code       (code_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_limit   <= UpperLimitReset;
         cfg_ff.lower_limit   <= LowerLimitReset;
         cfg_ff.ramp_rate     <= RampRateReset;
         cfg_ff.stall_ticks   <= StallTicksReset;
         state_ff.width_one   <= WidthReset;
         state_ff.width_two   <= WidthReset;
         state_ff.stall_count <= StallCountReset;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (reg_index_type'(csr_index))
               REG_UPPER_LIMIT: cfg_ff.upper_limit <= csr_data;
               REG_LOWER_LIMIT: cfg_ff.lower_limit <= csr_data;
               REG_RAMP_RATE:   cfg_ff.ramp_rate   <= csr_data;
               REG_STALL_TICKS: cfg_ff.stall_ticks <= csr_data;
               default: ;
            endcase
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         kind_ff <= kind_type'(req_kind);
         code_ff <= code_type'(req_switch_code);
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_servo_one_width = result_ff.servo_one_width;
   assign rsp_servo_two_width = result_ff.servo_two_width;
   assign rsp_pulse_active    = result_ff.pulse_active;
   assign rsp_main_lamps      = result_ff.main_lamps;
   assign rsp_lower_lamps     = result_ff.lower_lamps;

endmodule

// ===== tb/tb_dual_servo_ramp_turnout_signal.sv =====
// self-checking testbench for the dual servo turnout driver with signal lamps
module tb_dual_servo_ramp_turnout_signal;
   import dsrts_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned PhaseWords = 180;

   typedef struct packed {
      kind_type kind;
      code_type code;
   } turnout_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind = 1'b0;
   logic [1:0]           req_switch_code = 2'd0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WidthBits-1:0] rsp_servo_one_width;
   logic [WidthBits-1:0] rsp_servo_two_width;
   logic                 rsp_pulse_active;
   logic [7:0]           rsp_main_lamps;
   logic [1:0]           rsp_lower_lamps;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = 2'd0;
   logic [WidthBits-1:0] csr_data = '0;

   dual_servo_ramp_turnout_signal uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_switch_code(req_switch_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_servo_one_width(rsp_servo_one_width),
      .rsp_servo_two_width(rsp_servo_two_width),
      .rsp_pulse_active(rsp_pulse_active),
      .rsp_main_lamps(rsp_main_lamps),
      .rsp_lower_lamps(rsp_lower_lamps),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow of the block's registers and servo state
   cfg_type              limits = '{UpperLimitReset, LowerLimitReset, RampRateReset,
                                    StallTicksReset};
   logic [WidthBits-1:0] pos_one = WidthReset;
   logic [WidthBits-1:0] pos_two = WidthReset;
   logic [WidthBits-1:0] stall_left = StallCountReset;

   turnout_word_type     words_to_send[$];
   result_type           awaited_results[$];

   int unsigned          send_idle_pct = 0;
   int unsigned          recv_stall_pct = 0;
   logic                 long_hold = 1'b0;
   logic                 sender_paused = 1'b0;
   int unsigned          words_sent = 0;
   int unsigned          results_checked = 0;
   int unsigned          mismatches = 0;
   int unsigned          settings_used = 1;
   int unsigned          cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_dual_servo_ramp_turnout_signal failed");
         $finish;
      end
   end

   function automatic logic [WidthBits-1:0] ramp_toward_lower(logic [WidthBits-1:0] w);
      if (int'(w) >= int'(limits.lower_limit) + int'(limits.ramp_rate))
         return w - limits.ramp_rate;
      return limits.lower_limit;
   endfunction

   function automatic logic [WidthBits-1:0] ramp_toward_upper(logic [WidthBits-1:0] w);
      if (int'(w) <= int'(limits.upper_limit) - int'(limits.ramp_rate))
         return w + limits.ramp_rate;
      return limits.upper_limit;
   endfunction

   function automatic logic strictly_between(logic [WidthBits-1:0] w);
      return (w < limits.upper_limit) && (w > limits.lower_limit);
   endfunction

   function automatic void predict_turnout(kind_type kind, code_type code);
      result_type     r;
      logic [8:0]     span_sum;
      logic           one_up, one_low, two_up, two_low;
      logic           left_g, center_g, right_g;
      r = '0;
      left_g = 1'b0;
      center_g = 1'b0;
      right_g = 1'b0;
      if (kind == KIND_INIT) begin
         case (code)
            CODE_LEFT: begin
               pos_one = limits.upper_limit;
               pos_two = limits.upper_limit;
            end
            CODE_CENTER: begin
               pos_one = limits.lower_limit;
               pos_two = limits.upper_limit;
            end
            CODE_RIGHT: begin
               pos_one = limits.lower_limit;
               pos_two = limits.lower_limit;
            end
            default: begin
               span_sum = {1'b0, limits.upper_limit} + {1'b0, limits.lower_limit};
               pos_one = span_sum[8:1];
               pos_two = span_sum[8:1];
            end
         endcase
         stall_left = limits.stall_ticks;
         r.pulse_active = 1'b0;
         r.main_lamps = MainLampsAllRed;
         r.lower_lamps = LowerLampRed;
      end else begin
         if (code != CODE_UNKNOWN) begin
            case (code)
               CODE_LEFT: begin
                  pos_one = ramp_toward_lower(pos_one);
                  pos_two = ramp_toward_upper(pos_two);
               end
               CODE_CENTER: begin
                  pos_one = ramp_toward_lower(pos_one);
                  pos_two = ramp_toward_lower(pos_two);
               end
               default: begin
                  pos_one = ramp_toward_upper(pos_one);
                  pos_two = ramp_toward_lower(pos_two);
               end
            endcase
            if (strictly_between(pos_one) || strictly_between(pos_two))
               stall_left = limits.stall_ticks;
         end
         if (stall_left != 0) begin
            r.pulse_active = 1'b1;
            stall_left = stall_left - 1'b1;
         end
         // equal limits count as sitting at the upper one
         one_up = (pos_one == limits.upper_limit);
         one_low = !one_up && (pos_one == limits.lower_limit);
         two_up = (pos_two == limits.upper_limit);
         two_low = !two_up && (pos_two == limits.lower_limit);
         left_g = one_low && two_up && (code == CODE_LEFT);
         center_g = one_low && two_low && (code == CODE_CENTER);
         right_g = one_up && two_low && (code == CODE_RIGHT);
         r.lower_lamps = left_g ? LowerLampGreen : (right_g ? LowerLampYellow : LowerLampRed);
         r.main_lamps = {!center_g, center_g, !left_g, left_g,
                         !center_g, center_g, !right_g, right_g};
      end
      r.servo_one_width = pos_one;
      r.servo_two_width = pos_two;
      awaited_results.push_back(r);
   endfunction

   // request driver
   always @(posedge clock) begin
      turnout_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_turnout(kind_type'(req_kind), code_type'(req_switch_code));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (words_to_send.size() > 0 && !sender_paused &&
                $urandom_range(99) >= send_idle_pct) begin
               w = words_to_send.pop_front();
               req_valid <= 1'b1;
               req_kind <= w.kind;
               req_switch_code <= w.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string field, int got, int want);
      mismatches++;
      $display("mismatch at response %0d: %s got %0d want %0d",
               results_checked, field, got, want);
   endtask

   // response monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_servo_one_width !== want.servo_one_width)
                  report_mismatch("servo_one_width", rsp_servo_one_width,
                                  want.servo_one_width);
               if (rsp_servo_two_width !== want.servo_two_width)
                  report_mismatch("servo_two_width", rsp_servo_two_width,
                                  want.servo_two_width);
               if (rsp_pulse_active !== want.pulse_active)
                  report_mismatch("pulse_active", rsp_pulse_active, want.pulse_active);
               if (rsp_main_lamps !== want.main_lamps)
                  report_mismatch("main_lamps", rsp_main_lamps, want.main_lamps);
               if (rsp_lower_lamps !== want.lower_lamps)
                  report_mismatch("lower_lamps", rsp_lower_lamps, want.lower_lamps);
            end
            results_checked++;
         end
      end
   end

   task automatic queue_word(kind_type kind, code_type code);
      turnout_word_type w;
      w.kind = kind;
      w.code = code;
      words_to_send.push_back(w);
   endtask

   task automatic wait_idle();
      while (words_to_send.size() > 0 || req_valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [WidthBits-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_UPPER_LIMIT: limits.upper_limit = val;
         REG_LOWER_LIMIT: limits.lower_limit = val;
         REG_RAMP_RATE:   limits.ramp_rate = val;
         default:         limits.stall_ticks = val;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(logic [7:0] upper, logic [7:0] lower, logic [7:0] rate,
                             logic [7:0] stall);
      write_reg(REG_UPPER_LIMIT, upper);
      write_reg(REG_LOWER_LIMIT, lower);
      write_reg(REG_RAMP_RATE, rate);
      write_reg(REG_STALL_TICKS, stall);
      settings_used++;
   endtask

   // runs of one code let the servos reach their limits; inits and lone ticks are noise
   task automatic queue_random_words(int unsigned count);
      int unsigned n;
      int unsigned run;
      int unsigned pick;
      code_type    code;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         code = code_type'($urandom_range(3));
         if (pick < 8) begin
            queue_word(KIND_INIT, code);
            n++;
         end else if (pick < 15) begin
            queue_word(KIND_TICK, code);
            n++;
         end else begin
            run = $urandom_range(1, 40);
            repeat (run) queue_word(KIND_TICK, code);
            n += run;
         end
      end
   endtask

   initial begin
      int unsigned held;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every init and tick code from the reset settings
      queue_word(KIND_INIT, CODE_LEFT);
      queue_word(KIND_INIT, CODE_CENTER);
      queue_word(KIND_INIT, CODE_RIGHT);
      queue_word(KIND_INIT, CODE_UNKNOWN);
      queue_word(KIND_TICK, CODE_UNKNOWN);
      queue_word(KIND_TICK, CODE_LEFT);
      queue_word(KIND_TICK, CODE_CENTER);
      queue_word(KIND_TICK, CODE_RIGHT);
      wait_idle();

      // full range in one step: every route lights at once, countdown zero
      set_limits(8'd255, 8'd0, 8'd255, 8'd0);
      queue_word(KIND_INIT, CODE_LEFT);
      queue_word(KIND_TICK, CODE_LEFT);
      queue_word(KIND_TICK, CODE_LEFT);
      queue_word(KIND_TICK, CODE_CENTER);
      queue_word(KIND_TICK, CODE_RIGHT);
      queue_word(KIND_TICK, CODE_UNKNOWN);
      queue_word(KIND_INIT, CODE_RIGHT);
      queue_word(KIND_INIT, CODE_CENTER);
      queue_word(KIND_INIT, CODE_UNKNOWN);
      queue_word(KIND_TICK, CODE_RIGHT);

      for (int ph = 0; ph < 9; ph++) begin
         wait_idle();
         case (ph)
            0: set_limits(UpperLimitReset, LowerLimitReset, RampRateReset, StallTicksReset);
            1: set_limits(8'd255, 8'd0, 8'd1, 8'd255);
            2: set_limits(8'd200, 8'd40, 8'd7, 8'd3);
            3: set_limits(8'd100, 8'd100, 8'd5, 8'd10);
            4: set_limits(8'd60, 8'd180, 8'd9, 8'd20);
            5: set_limits(8'd255, 8'd0, 8'd255, 8'd0);
            6: set_limits(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
            7: set_limits(8'($urandom_range(128, 255)), 8'($urandom_range(127)),
                          8'($urandom_range(15)), 8'($urandom_range(255)));
            default: set_limits(8'd0, 8'd0, 8'd0, 8'd1);
         endcase
         case (ph % 4)
            0: begin
               send_idle_pct <= 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 48;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               recv_stall_pct <= 48;
            end
            default: begin
               send_idle_pct <= 24;
               recv_stall_pct <= 24;
            end
         endcase
         queue_random_words(PhaseWords);
         if (ph == 4) begin
            // receiver holds off long enough to back up the pipeline
            while (words_sent < 10) @(posedge clock);
            long_hold <= 1'b1;
            held = 0;
            while (held < 80) begin
               @(posedge clock);
               held++;
            end
            long_hold <= 1'b0;
         end
         if (ph == 6) begin
            while (words_to_send.size() > PhaseWords / 2) @(posedge clock);
            sender_paused <= 1'b1;
            @(posedge clock);
            while (req_valid || awaited_results.size() > 0) @(posedge clock);
            sender_paused <= 1'b0;
         end
      end
      wait_idle();
      repeat (10) @(posedge clock);

      $display("sent %0d request words over %0d register settings, checked %0d responses",
               words_sent, settings_used, results_checked);
      $display("covered init and tick on all codes, equal, crossed and extreme limits");
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("tb_dual_servo_ramp_turnout_signal passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  awaited_results.size());
         $display("tb_dual_servo_ramp_turnout_signal failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dsrts_pkg.sv
hw/rtl/dsrts_core.sv
hw/rtl/dual_servo_ramp_turnout_signal.sv
tb/tb_dual_servo_ramp_turnout_signal.sv
